// File: hdl/lz77_pkg.sv
// Shared types and constants of the LZ77 triple encoder.
`timescale 1ns / 1ps
package lz77_pkg;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned OFF_W  = 8;
    localparam int unsigned LEN_W  = 6;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LENGTH    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD_LENGTH = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_in_item;

    typedef struct packed {
        logic [OFF_W-1:0]  match_offset;
        logic [LEN_W-1:0]  match_length;
        logic [BYTE_W-1:0] next_symbol;
        logic              last_triple;
    } t_out_item;
endpackage

// File: hdl/lz77_stream_if.sv
// Valid/ready channel carrying one payload item.
`timescale 1ns / 1ps
interface lz77_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/lz77_window.sv
// Circular byte window with one write port and one registered read port.
`timescale 1ns / 1ps
module lz77_window #(
    parameter int unsigned DEPTH = 512,
    parameter int unsigned AW    = 9
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [lz77_pkg::BYTE_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic [lz77_pkg::BYTE_W-1:0] o_rdata
);
    import lz77_pkg::*;
    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// File: hdl/lz77_triple_encoder.sv
// Top level of the LZ77 triple encoder: sequencer around one window compare.
// Speed is set by the single window read port feeding one byte comparator: each triple
// reads and compares one byte pair at a time for every offset, and it also waits on output
// stalls. One item is worked on at a time; ready stays low until its triples are taken.
// Synchronous active-low reset clears pointers, fills and output valid, and sets the
// configuration registers to their defaults.
`timescale 1ns / 1ps
module lz77_triple_encoder #(
    parameter int unsigned MAX_SEARCH    = 255,
    parameter int unsigned MAX_LOOKAHEAD = 63,
    parameter int unsigned WINDOW_DEPTH  = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lz77_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lz77_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    lz77_stream_if.sink                       in_ch,
    lz77_stream_if.source                     out_ch
);
    import lz77_pkg::*;
    localparam int unsigned AW = $clog2(WINDOW_DEPTH);
    localparam int unsigned CAP = WINDOW_DEPTH - MAX_LOOKAHEAD - 1;
    localparam int unsigned REACH_LIM = (MAX_SEARCH < CAP) ? MAX_SEARCH : CAP;
    localparam logic [OFF_W-1:0] REACH_LIM_V = OFF_W'(REACH_LIM);
    localparam logic [LEN_W-1:0] LA_LIM_V = LEN_W'(MAX_LOOKAHEAD);
    localparam logic [6:0] FILL_CAP = 7'(MAX_LOOKAHEAD + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_OFF, S_RD_A, S_RD_B, S_CMP, S_SYM, S_OUT
    } t_state;

    t_state            r_state;
    logic [AW-1:0]     r_wp;
    logic [6:0]        r_fill;
    logic [7:0]        r_hist;
    logic [7:0]        r_search;
    logic [5:0]        r_la;
    logic              r_last;
    logic [AW-1:0]     r_start;
    logic [OFF_W-1:0]  r_reach, r_off, r_best_off;
    logic [LEN_W-1:0]  r_maxlen, r_len, r_best_len;
    logic [BYTE_W-1:0] r_a;
    logic [AW-1:0]     r_raddr;
    logic              r_we;
    t_out_item         r_out;
    logic              r_out_valid;

    logic [BYTE_W-1:0] w_rdata;
    logic [5:0]        w_la_eff;
    logic [OFF_W-1:0]  w_reach;
    logic [6:0]        w_fill_m1;
    logic              w_need;
    logic [6:0]        w_consume;
    logic [8:0]        w_hist_sum;

    lz77_window #(.DEPTH(WINDOW_DEPTH), .AW(AW)) u_window (
        .i_clk   (i_clk),
        .i_we    (r_we),
        .i_waddr (r_wp),
        .i_wdata (r_out.next_symbol),
        .i_raddr (r_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_la_eff = (r_la > LA_LIM_V) ? LA_LIM_V : r_la;
        w_reach = r_search;
        if (w_reach > REACH_LIM_V) w_reach = REACH_LIM_V;
        if (w_reach > r_hist) w_reach = r_hist;
        w_fill_m1 = r_fill - 7'd1;
        if (r_last) begin
            w_need = (r_fill != 7'd0);
        end else begin
            w_need = (r_fill > {1'b0, w_la_eff});
        end
        w_consume = {1'b0, r_best_len} + 7'd1;
        w_hist_sum = {1'b0, r_hist} + {2'b00, w_consume};
    end

    assign in_ch.ready = (r_state == S_IDLE);
    assign out_ch.valid = r_out_valid;
    assign out_ch.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wp <= '0;
            r_fill <= '0;
            r_hist <= '0;
            r_search <= 8'd255;
            r_la <= 6'd15;
            r_out_valid <= 1'b0;
            r_we <= 1'b0;
            r_last <= 1'b0;
        end else begin
            r_we <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_SEARCH_LENGTH:    r_search <= i_cfg_data;
                    REG_LOOKAHEAD_LENGTH: r_la <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        // The byte is parked in the output register's symbol
                        // field until the window write the next cycle.
                        r_out.next_symbol <= in_ch.payload.data_byte;
                        r_we <= 1'b1;
                        r_last <= in_ch.payload.last_byte;
                        if (r_fill < FILL_CAP) r_fill <= r_fill + 7'd1;
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (r_we) begin
                        r_wp <= r_wp + AW'(1);
                    end else if (w_need) begin
                        r_start <= r_wp - AW'(r_fill);
                        r_reach <= w_reach;
                        if (r_last && (w_fill_m1 < {1'b0, w_la_eff})) begin
                            r_maxlen <= w_fill_m1[5:0];
                        end else begin
                            r_maxlen <= w_la_eff;
                        end
                        r_off <= 8'd1;
                        r_best_off <= '0;
                        r_best_len <= '0;
                        r_state <= S_OFF;
                    end else begin
                        if (r_last) begin
                            r_fill <= '0;
                            r_hist <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_OFF: begin
                    r_len <= '0;
                    // The offset counter wraps to zero after the widest reach.
                    if (r_off > r_reach || r_off == '0 || r_maxlen == '0) begin
                        r_raddr <= r_start + AW'(r_best_len);
                        r_state <= S_SYM;
                    end else begin
                        r_raddr <= r_start - AW'(r_off);
                        r_state <= S_RD_A;
                    end
                end
                S_RD_A: begin
                    r_raddr <= r_start + AW'(r_len);
                    r_state <= S_RD_B;
                end
                S_RD_B: begin
                    r_a <= w_rdata;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_a == w_rdata && r_len + LEN_W'(1) < r_maxlen) begin
                        r_len <= r_len + LEN_W'(1);
                        r_raddr <= r_start - AW'(r_off) + AW'(r_len) + AW'(1);
                        r_state <= S_RD_A;
                    end else begin
                        if (r_a == w_rdata) begin
                            if (r_len + LEN_W'(1) > r_best_len) begin
                                r_best_len <= r_len + LEN_W'(1);
                                r_best_off <= r_off;
                            end
                        end else if (r_len > r_best_len) begin
                            r_best_len <= r_len;
                            r_best_off <= r_off;
                        end
                        r_off <= r_off + 8'd1;
                        r_state <= S_OFF;
                    end
                end
                S_SYM: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid) begin
                        r_out.match_offset <= r_best_off;
                        r_out.match_length <= r_best_len;
                        r_out.next_symbol <= w_rdata;
                        r_out.last_triple <= r_last && (r_fill == w_consume);
                        r_out_valid <= 1'b1;
                        r_fill <= r_fill - w_consume;
                        r_hist <= w_hist_sum[8] ? 8'd255 : w_hist_sum[7:0];
                    end else if (out_ch.ready) begin
                        r_out_valid <= 1'b0;
                        r_state <= S_DECIDE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: tb/sv/lz77_triple_checker.sv
// Checker for the LZ77 triple encoder: predicts triples and compares them.
`timescale 1ns / 1ps
module lz77_triple_checker #(
    parameter int unsigned MAX_SEARCH    = 255,
    parameter int unsigned MAX_LOOKAHEAD = 63,
    parameter int unsigned WINDOW_DEPTH  = 512
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lz77_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lz77_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  lz77_pkg::t_in_item              i_in_item,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  lz77_pkg::t_out_item             i_out_item,
    output int                              o_fail_count,
    output int                              o_pending
);
    import lz77_pkg::*;

    logic [7:0]  window_mem [WINDOW_DEPTH];
    int unsigned wr_ptr;
    int unsigned ahead_fill;
    int unsigned history;
    int unsigned search_reg;
    int unsigned ahead_reg;
    t_out_item   triple_queue [$];

    function automatic logic [7:0] win_byte(int unsigned pos);
        return window_mem[pos % WINDOW_DEPTH];
    endfunction

    // Finds the longest match for the look-ahead front and consumes it.
    task automatic encode_triple(int unsigned maxlen, logic last);
        int unsigned start, reach, best_off, best_len, len, back;
        t_out_item   t;
        start = (wr_ptr + 2 * WINDOW_DEPTH - ahead_fill) % WINDOW_DEPTH;
        reach = search_reg;
        if (reach > MAX_SEARCH) reach = MAX_SEARCH;
        if (reach > WINDOW_DEPTH - MAX_LOOKAHEAD - 1) reach = WINDOW_DEPTH - MAX_LOOKAHEAD - 1;
        if (reach > history) reach = history;
        best_off = 0;
        best_len = 0;
        for (int unsigned off = 1; off <= reach; off++) begin
            back = start + 2 * WINDOW_DEPTH - off;
            len = 0;
            while (len < maxlen && win_byte(back + len) == win_byte(start + len)) len++;
            if (len > best_len) begin
                best_len = len;
                best_off = off;
            end
        end
        t.match_offset = best_off[OFF_W-1:0];
        t.match_length = best_len[LEN_W-1:0];
        t.next_symbol  = win_byte(start + best_len);
        // Only the triple that empties the look-ahead of a flush is the last one.
        t.last_triple  = last && (ahead_fill == best_len + 1);
        triple_queue.push_back(t);
        ahead_fill -= best_len + 1;
        history += best_len + 1;
        if (history > 255) history = 255;
    endtask

    task automatic absorb_byte(t_in_item item);
        int unsigned limit, maxlen;
        int          n;
        limit = (ahead_reg > MAX_LOOKAHEAD) ? MAX_LOOKAHEAD : ahead_reg;
        n = 0;
        window_mem[wr_ptr % WINDOW_DEPTH] = item.data_byte;
        wr_ptr = (wr_ptr + 1) % WINDOW_DEPTH;
        if (ahead_fill < MAX_LOOKAHEAD + 1) ahead_fill++;
        if (item.last_byte) begin
            while (ahead_fill > 0 && n < 64) begin
                maxlen = ahead_fill - 1;
                if (maxlen > limit) maxlen = limit;
                encode_triple(maxlen, 1'b1);
                n++;
            end
            ahead_fill = 0;
            history = 0;
        end else begin
            while (ahead_fill > limit && n < 64) begin
                encode_triple(limit, 1'b0);
                n++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item exp_t;
        if (!i_rst_n) begin
            ahead_fill = 0;
            history = 0;
            search_reg = 255;
            ahead_reg = 15;
            wr_ptr = 0;
            triple_queue.delete();
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_SEARCH_LENGTH) search_reg = i_cfg_data;
                else if (i_cfg_index == REG_LOOKAHEAD_LENGTH) ahead_reg = i_cfg_data[5:0];
            end
            if (i_out_valid && i_out_ready) begin
                if (triple_queue.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("Unexpected triple: off=%0d len=%0d sym=%0d last=%0d",
                                 i_out_item.match_offset, i_out_item.match_length,
                                 i_out_item.next_symbol, i_out_item.last_triple);
                end else begin
                    exp_t = triple_queue.pop_front();
                    if (exp_t !== i_out_item) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display({"Triple mismatch: expected off/len/sym/last ",
                                      "%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d"},
                                     exp_t.match_offset, exp_t.match_length,
                                     exp_t.next_symbol, exp_t.last_triple,
                                     i_out_item.match_offset, i_out_item.match_length,
                                     i_out_item.next_symbol, i_out_item.last_triple);
                    end
                end
            end
            // The input transfer is predicted after the output check, since a
            // triple caused by this byte cannot appear in the same cycle.
            if (i_in_valid && i_in_ready) absorb_byte(i_in_item);
            o_pending <= triple_queue.size();
        end
    end
endmodule

// File: tb/sv/lz77_triple_encoder_test.sv
// Testbench top of the LZ77 triple encoder: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module lz77_triple_encoder_test;
    import lz77_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_SEARCH_LENGTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    pending;
    longint                cycle_count = 0;
    logic [7:0]            pattern [$];

    lz77_stream_if #(.T(t_in_item))  byte_ch ();
    lz77_stream_if #(.T(t_out_item)) triple_ch ();

    lz77_triple_encoder DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .in_ch(byte_ch.sink), .out_ch(triple_ch.source)
    );

    lz77_triple_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(byte_ch.valid), .i_in_ready(byte_ch.ready),
        .i_in_item(byte_ch.payload), .i_out_valid(triple_ch.valid),
        .i_out_ready(triple_ch.ready), .i_out_item(triple_ch.payload),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: the search for each triple is bounded apart from output stalls,
    // and every triple consumes at least one byte.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 40000000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side is mostly ready, with stalls of random length now and then.
    initial begin
        int stall;
        stall = 0;
        triple_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall != 0) begin
                triple_ch.ready <= 1'b0;
                stall--;
            end else begin
                triple_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall = gap_length();
            end
        end
    end

    // Valid stays high after a transfer until the next byte or an idle period.
    task automatic send_byte(logic [7:0] value, logic last, bit allow_gap);
        t_in_item item;
        int       gap;
        item.data_byte = value;
        item.last_byte = last;
        gap = allow_gap ? gap_length() : 0;
        if (gap != 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.payload <= item;
        byte_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!byte_ch.ready);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_we <= 1'b1;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every predicted triple arrived, then adds an idle tail.
    task automatic drain();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // Sends a stream of n bytes drawn at random, from a small alphabet, or as repeats of recent bytes.
    task automatic send_stream(int n, int style);
        logic [7:0] b;
        pattern.delete();
        for (int k = 0; k < n; k++) begin
            case (style)
                0: b = 8'($urandom_range(0, 255));
                1: b = 8'h40 + 8'($urandom_range(0, 2));
                default: b = (k >= 4 && $urandom_range(0, 3) != 0) ?
                             pattern[k - $urandom_range(1, 4)] : 8'($urandom_range(0, 255));
            endcase
            pattern.push_back(b);
            send_byte(b, k == n - 1, 1'b1);
        end
    endtask

    initial begin
        byte_ch.valid = 1'b0;
        byte_ch.payload = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single byte, extreme bytes, runs.
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b1, 1'b0);
        for (int k = 0; k < 20; k++) send_byte(8'hA5, k == 19, 1'b0);
        drain();

        // Zero look-ahead and zero search both force literals.
        write_reg(REG_LOOKAHEAD_LENGTH, 8'd0);
        send_stream(6, 1);
        drain();
        write_reg(REG_LOOKAHEAD_LENGTH, 8'd63);
        write_reg(REG_SEARCH_LENGTH, 8'd0);
        send_stream(6, 1);
        drain();

        // Lowered look-ahead in mid-stream leaves extra bytes to flush.
        write_reg(REG_SEARCH_LENGTH, 8'd1);
        for (int k = 0; k < 30; k++) send_byte(8'h55, 1'b0, 1'b1);
        drain();
        write_reg(REG_LOOKAHEAD_LENGTH, 8'd2);
        send_byte(8'h55, 1'b0, 1'b0);
        drain();
        send_byte(8'h56, 1'b1, 1'b0);
        drain();

        // Random streams under several register settings.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_SEARCH_LENGTH, 8'd255);
                    write_reg(REG_LOOKAHEAD_LENGTH, 8'd63);
                end
                1: begin
                    write_reg(REG_SEARCH_LENGTH, 8'd4);
                    write_reg(REG_LOOKAHEAD_LENGTH, 8'd1);
                end
                default: begin
                    write_reg(REG_SEARCH_LENGTH, 8'($urandom_range(1, 40)));
                    write_reg(REG_LOOKAHEAD_LENGTH, 8'($urandom_range(1, 12)));
                end
            endcase
            send_stream($urandom_range(4, 12), $urandom_range(0, 2));
            send_stream($urandom_range(4, 12), $urandom_range(1, 2));
            drain();
        end

        // End of run: every triple accounted for, then a short idle tail.
        drain();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
